[rtl/word_wrap_by_pixel_width_unit_assert.svh]
// assertion macros for the word wrap unit
`ifndef WORD_WRAP_BY_PIXEL_WIDTH_UNIT_ASSERT_SVH
`define WORD_WRAP_BY_PIXEL_WIDTH_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WWPW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wwpw: same-cycle check failed");

// next-cycle implication, checked outside reset
`define WWPW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wwpw: next-cycle check failed");

`endif

[rtl/wwpw_pkg.sv]
package wwpw_pkg;

   // field widths
   localparam int CHAR_W   = 8;
   localparam int ADV_W    = 12;
   localparam int HEIGHT_W = 12;
   localparam int UWIDTH_W = 16;
   localparam int WSUM_W   = 20;

   // default column limit
   localparam int DEF_MAX_LINE_COLS = 4096;

   // item kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   // break characters
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_USABLE_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_HEIGHT = 1'b1;
   localparam int CSR_DATA_W = UWIDTH_W;

   localparam logic [HEIGHT_W-1:0] RESET_EMPTY_HEIGHT = 12'd16;

   // request payload: character, advance, char_height
   localparam int REQ_DATA_W = CHAR_W + ADV_W + HEIGHT_W;

endpackage

[rtl/word_wrap_by_pixel_width_unit.sv]
// Greedy pixel-width word wrap. Character items (tuser low) stream in on req_ with their byte,
// advance width and font line height; an end-of-line item (tuser high) closes the line. Each
// time a character would push the running width past a nonzero usable_width, and the open
// segment already holds a character, the unit sends one segment on rsp_ (start column, end
// column, height), breaking after the last space or tab inside the segment or cutting hard
// before the current character; the end-of-line item always sends the final segment with tlast
// set. The unit takes one item per clock: an item is registered on transfer, the line state
// and the result are worked out from that register once the output register is free or being
// drained, and the result lands in an output register. The per-line state update (a 21-bit
// add and compare against usable_width plus the break bookkeeping) is combinational and sets
// the rate. The input stage stalls only while a result waits in the output register and
// rsp_tready is low. Columns stop counting at MAX_LINE_COLS; characters past that are dropped
// until the end of the line. Write csr_ registers only while the unit is idle.
`include "word_wrap_by_pixel_width_unit_assert.svh"

module word_wrap_by_pixel_width_unit #(
   parameter int MAX_LINE_COLS = wwpw_pkg::DEF_MAX_LINE_COLS,
   // derived: column width and packed result width
   parameter int COL_W      = $clog2(MAX_LINE_COLS + 1),
   parameter int RSP_DATA_W = ((2 * COL_W + wwpw_pkg::HEIGHT_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,

   // configuration writes
   input  logic                              csr_we,
   input  logic [wwpw_pkg::CSR_IDX_W-1:0]    csr_addr,
   input  logic [wwpw_pkg::CSR_DATA_W-1:0]   csr_wdata,

   // character stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wwpw_pkg::REQ_DATA_W-1:0]   req_tdata,  // character, advance, char_height
   input  logic                              req_tuser,  // kind

   // segment stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_DATA_W-1:0]             rsp_tdata,  // start_col, end_col, seg_height
   output logic                              rsp_tlast   // line_end
);

   localparam int HW = wwpw_pkg::HEIGHT_W;
   localparam int AW = wwpw_pkg::ADV_W;
   localparam int CW = wwpw_pkg::CHAR_W;
   localparam int SW = wwpw_pkg::WSUM_W;
   localparam int PAD_W = RSP_DATA_W - (2 * COL_W + HW);
   localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(MAX_LINE_COLS);

   typedef struct packed {
      logic          kind;
      logic [CW-1:0] character;
      logic [AW-1:0] advance;
      logic [HW-1:0] char_height;
   } item_type;

   // saturating width sum
   function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [AW-1:0] b);
      logic [SW:0] s;
      s = {1'b0, a} + {{(SW + 1 - AW){1'b0}}, b};
      return s[SW] ? {SW{1'b1}} : s[SW-1:0];
   endfunction

   function automatic logic [HW-1:0] hmax(input logic [HW-1:0] a, input logic [HW-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // configuration registers
   logic [wwpw_pkg::UWIDTH_W-1:0] usable_width_ff;
   logic [HW-1:0]                 empty_height_ff;

   // input stage
   logic     stage_valid_ff, stage_valid_in;
   item_type stage_ff;
   logic     stage_go;

   // line state
   logic [COL_W-1:0] column_ff,    column_in;
   logic [COL_W-1:0] seg_start_ff, seg_start_in;
   logic [SW-1:0]    width_sum_ff, width_sum_in;
   logic [HW-1:0]    tallest_ff,   tallest_in;
   logic [COL_W-1:0] brk_pos_ff,   brk_pos_in;
   logic             brk_valid_ff, brk_valid_in;
   logic [SW-1:0]    wab_ff,       wab_in;    // width after break
   logic [HW-1:0]    tab_ff,       tab_in;    // tallest after break

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]      rsp_start_ff;
   logic [COL_W-1:0]      rsp_end_ff;
   logic [HW-1:0]         rsp_height_ff;
   logic                  rsp_last_ff;

   // result of the current stage item
   logic             emit;
   logic [COL_W-1:0] out_start;
   logic [COL_W-1:0] out_end;
   logic [HW-1:0]    out_height;
   logic             out_last;

   // decision terms
   logic             is_ws;
   logic [SW:0]      trial_sum;
   logic             over;
   logic             use_break;
   logic [HW-1:0]    seg_h;

   // the stage moves on whenever the output register is free or being drained
   assign stage_go   = stage_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~stage_valid_ff | stage_go;

   always_comb begin
      if (req_tvalid && req_tready) begin
         stage_valid_in = 1'b1;
      end else if (stage_go) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   assign is_ws     = (stage_ff.character == wwpw_pkg::CHAR_SPACE) ||
                      (stage_ff.character == wwpw_pkg::CHAR_TAB);
   assign trial_sum = {1'b0, width_sum_ff} + {{(SW + 1 - AW){1'b0}}, stage_ff.advance};
   assign over      = (usable_width_ff != '0) &&
                      (trial_sum > {{(SW + 1 - wwpw_pkg::UWIDTH_W){1'b0}}, usable_width_ff}) &&
                      (column_ff > seg_start_ff);
   assign use_break = brk_valid_ff && (brk_pos_ff > seg_start_ff);
   assign seg_h     = (tallest_ff != '0) ? tallest_ff : empty_height_ff;

   // line state update, one item per cycle unless the stage stalls
   always_comb begin
      column_in    = column_ff;
      seg_start_in = seg_start_ff;
      width_sum_in = width_sum_ff;
      tallest_in   = tallest_ff;
      brk_pos_in   = brk_pos_ff;
      brk_valid_in = brk_valid_ff;
      wab_in       = wab_ff;
      tab_in       = tab_ff;
      emit         = 1'b0;
      out_start    = seg_start_ff;
      out_end      = column_ff;
      out_height   = seg_h;
      out_last     = 1'b0;
      if (stage_go) begin
         if (stage_ff.kind == wwpw_pkg::KIND_EOL) begin
            // close the line and start over
            emit       = 1'b1;
            out_last   = 1'b1;
            out_height = ((usable_width_ff != '0) && (tallest_ff != '0)) ?
                         tallest_ff : empty_height_ff;
            column_in    = '0;
            seg_start_in = '0;
            width_sum_in = '0;
            tallest_in   = '0;
            brk_pos_in   = '0;
            brk_valid_in = 1'b0;
            wab_in       = '0;
            tab_in       = '0;
         end else if (column_ff < COL_LIMIT) begin
            if (over) begin
               emit = 1'b1;
               if (use_break) begin
                  // break at the whitespace, it is dropped
                  out_end      = brk_pos_ff;
                  seg_start_in = brk_pos_ff + COL_W'(1);
                  width_sum_in = sat_add(wab_ff, stage_ff.advance);
                  tallest_in   = hmax(tab_ff, stage_ff.char_height);
               end else begin
                  // hard cut before this character
                  seg_start_in = column_ff;
                  width_sum_in = {{(SW - AW){1'b0}}, stage_ff.advance};
                  tallest_in   = stage_ff.char_height;
               end
               brk_valid_in = is_ws;
               brk_pos_in   = is_ws ? column_ff : '0;
               wab_in       = '0;
               tab_in       = '0;
            end else begin
               width_sum_in = sat_add(width_sum_ff, stage_ff.advance);
               tallest_in   = hmax(tallest_ff, stage_ff.char_height);
               if (is_ws) begin
                  brk_valid_in = 1'b1;
                  brk_pos_in   = column_ff;
                  wab_in       = '0;
                  tab_in       = '0;
               end else begin
                  wab_in = sat_add(wab_ff, stage_ff.advance);
                  tab_in = hmax(tab_ff, stage_ff.char_height);
               end
            end
            column_in = column_ff + COL_W'(1);
         end
      end
   end

   always_comb begin
      if (stage_go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control and configuration state
   always_ff @(posedge clock) begin
      if (reset) begin
         usable_width_ff <= '0;
         empty_height_ff <= wwpw_pkg::RESET_EMPTY_HEIGHT;
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         column_ff       <= '0;
         seg_start_ff    <= '0;
         width_sum_ff    <= '0;
         tallest_ff      <= '0;
         brk_pos_ff      <= '0;
         brk_valid_ff    <= 1'b0;
         wab_ff          <= '0;
         tab_ff          <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               wwpw_pkg::CSR_USABLE_WIDTH: usable_width_ff <= csr_wdata;
               wwpw_pkg::CSR_EMPTY_HEIGHT: empty_height_ff <= csr_wdata[HW-1:0];
               default: ;
            endcase
         end
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         column_ff      <= column_in;
         seg_start_ff   <= seg_start_in;
         width_sum_ff   <= width_sum_in;
         tallest_ff     <= tallest_in;
         brk_pos_ff     <= brk_pos_in;
         brk_valid_ff   <= brk_valid_in;
         wab_ff         <= wab_in;
         tab_ff         <= tab_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         stage_ff.kind        <= req_tuser;
         stage_ff.character   <= req_tdata[CW-1:0];
         stage_ff.advance     <= req_tdata[CW+AW-1:CW];
         stage_ff.char_height <= req_tdata[CW+AW+HW-1:CW+AW];
      end
      if (stage_go && emit) begin
         rsp_start_ff  <= out_start;
         rsp_end_ff    <= out_end;
         rsp_height_ff <= out_height;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_height_ff, rsp_end_ff, rsp_start_ff};
   assign rsp_tlast  = rsp_last_ff;

   // segment never starts beyond the current column
   `WWPW_ASSERT_NOW(a_seg_order, clock, reset, 1'b1, seg_start_ff <= column_ff)
   // column counting stops at the limit
   `WWPW_ASSERT_NOW(a_col_limit, clock, reset, 1'b1, column_ff <= COL_LIMIT)
   // a recorded break lies behind the current column
   `WWPW_ASSERT_NOW(a_brk_behind, clock, reset, brk_valid_ff, brk_pos_ff < column_ff)
   // end of line clears the line state and leaves a last segment waiting
   `WWPW_ASSERT_NEXT(a_eol_clear, clock, reset,
      stage_go && (stage_ff.kind == wwpw_pkg::KIND_EOL),
      (column_ff == '0) && !brk_valid_ff && rsp_valid_ff && rsp_last_ff)

endmodule

[tb/tb_word_wrap_by_pixel_width_unit.sv]
`timescale 1ns / 100ps

module tb_word_wrap_by_pixel_width_unit;

   localparam int LINE_COLS = wwpw_pkg::DEF_MAX_LINE_COLS;
   localparam int COL_W     = $clog2(LINE_COLS + 1);
   localparam int RSP_W     = ((2 * COL_W + wwpw_pkg::HEIGHT_W + 7) / 8) * 8;
   localparam int WSUM_CAP  = (1 << wwpw_pkg::WSUM_W) - 1;

   // one character or end-of-line item as it goes on the wire
   typedef struct {
      logic                          kind;
      logic [wwpw_pkg::CHAR_W-1:0]   ch;
      logic [wwpw_pkg::ADV_W-1:0]    adv;
      logic [wwpw_pkg::HEIGHT_W-1:0] ht;
   } text_item_type;

   // one emitted line segment
   typedef struct {
      logic [COL_W-1:0]              start_col;
      logic [COL_W-1:0]              end_col;
      logic [wwpw_pkg::HEIGHT_W-1:0] seg_height;
      logic                          line_end;
   } segment_type;

   // receiver stall behavior
   typedef enum int {RX_STREAM, RX_RANDOM, RX_CHOKED} rx_mode_type;

   logic clock;
   logic reset = 1'b1;

   logic                            csr_we    = 1'b0;
   logic [wwpw_pkg::CSR_IDX_W-1:0]  csr_addr  = wwpw_pkg::CSR_USABLE_WIDTH;
   logic [wwpw_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [wwpw_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // character, advance, char_height
   logic                            req_tuser  = wwpw_pkg::KIND_CHAR;  // kind

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;  // start_col, end_col, seg_height
   logic                  rsp_tlast;  // line_end

   word_wrap_by_pixel_width_unit #(
      .MAX_LINE_COLS(LINE_COLS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // items waiting for the driver and segments waiting for the monitor
   text_item_type text_items[$];
   segment_type   expected_segments[$];

   // shadow copy of the registers and the line state
   logic [wwpw_pkg::UWIDTH_W-1:0] cfg_usable_width = '0;
   logic [wwpw_pkg::HEIGHT_W-1:0] cfg_empty_height = wwpw_pkg::RESET_EMPTY_HEIGHT;
   logic [COL_W-1:0]              wrap_col;
   logic [COL_W-1:0]              wrap_seg_start;
   logic [COL_W-1:0]              wrap_brk_pos;
   logic                          wrap_brk_valid;
   int unsigned                   wrap_width_sum;
   int unsigned                   wrap_width_after;
   logic [wwpw_pkg::HEIGHT_W-1:0] wrap_tallest;
   logic [wwpw_pkg::HEIGHT_W-1:0] wrap_tallest_after;

   // run statistics
   int items_accepted = 0;
   int lines_closed   = 0;
   int segs_checked   = 0;
   int wraps_checked  = 0;
   int mismatches     = 0;

   function automatic void clear_line_state();
      wrap_col           = '0;
      wrap_seg_start     = '0;
      wrap_brk_pos       = '0;
      wrap_brk_valid     = 1'b0;
      wrap_width_sum     = 0;
      wrap_width_after   = 0;
      wrap_tallest       = '0;
      wrap_tallest_after = '0;
   endfunction

   function automatic int unsigned sum_capped(int unsigned a, int unsigned b);
      return (a + b > WSUM_CAP) ? WSUM_CAP : a + b;
   endfunction

   // append one segment to the expectation queue
   function automatic void expect_segment(logic [COL_W-1:0] s, logic [COL_W-1:0] e,
                                          logic [wwpw_pkg::HEIGHT_W-1:0] h, logic last);
      segment_type seg;
      seg = '{s, e, h, last};
      expected_segments.insert(expected_segments.size(), seg);
   endfunction

   // append one item to the driver queue
   function automatic void queue_item(text_item_type it);
      text_items.insert(text_items.size(), it);
   endfunction

   // advance the wrap state by one accepted item, queueing the segment it emits
   function automatic void wrap_line_step(text_item_type it);
      logic                          is_ws;
      logic [wwpw_pkg::HEIGHT_W-1:0] h;
      if (it.kind == wwpw_pkg::KIND_EOL) begin
         // height falls back to the empty-line value when wrapping is off or nothing was tall
         h = (cfg_usable_width != 0 && wrap_tallest > 0) ? wrap_tallest : cfg_empty_height;
         expect_segment(wrap_seg_start, wrap_col, h, 1'b1);
         clear_line_state();
         return;
      end
      // saturated column: characters are dropped until end of line
      if (wrap_col >= LINE_COLS)
         return;
      is_ws = (it.ch == wwpw_pkg::CHAR_SPACE) || (it.ch == wwpw_pkg::CHAR_TAB);
      if (cfg_usable_width != 0 && wrap_width_sum + it.adv > cfg_usable_width &&
          wrap_col > wrap_seg_start) begin
         h = (wrap_tallest > 0) ? wrap_tallest : cfg_empty_height;
         if (wrap_brk_valid && wrap_brk_pos > wrap_seg_start) begin
            // soft break: whitespace is dropped, the tail moves to the next segment
            expect_segment(wrap_seg_start, wrap_brk_pos, h, 1'b0);
            wrap_seg_start = wrap_brk_pos + 1'b1;
            wrap_width_sum = sum_capped(wrap_width_after, it.adv);
            wrap_tallest   = (wrap_tallest_after > it.ht) ? wrap_tallest_after : it.ht;
         end else begin
            // hard cut before the current character
            expect_segment(wrap_seg_start, wrap_col, h, 1'b0);
            wrap_seg_start = wrap_col;
            wrap_width_sum = it.adv;
            wrap_tallest   = it.ht;
         end
         wrap_brk_valid     = is_ws;
         wrap_brk_pos       = is_ws ? wrap_col : '0;
         wrap_width_after   = 0;
         wrap_tallest_after = '0;
      end else begin
         wrap_width_sum = sum_capped(wrap_width_sum, it.adv);
         if (it.ht > wrap_tallest)
            wrap_tallest = it.ht;
         if (is_ws) begin
            wrap_brk_valid     = 1'b1;
            wrap_brk_pos       = wrap_col;
            wrap_width_after   = 0;
            wrap_tallest_after = '0;
         end else begin
            wrap_width_after = sum_capped(wrap_width_after, it.adv);
            if (it.ht > wrap_tallest_after)
               wrap_tallest_after = it.ht;
         end
      end
      wrap_col = wrap_col + 1'b1;
   endfunction

   initial clear_line_state();

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // sender: bursts of random length, random gaps, sometimes none at all
   text_item_type cur_item;
   int            burst_left = 0;
   int            gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            wrap_line_step(cur_item);
            items_accepted++;
         end
         // slot is free once the current item transferred or nothing is offered
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (text_items.size() > 0) begin
               cur_item = text_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_item.ht, cur_item.adv, cur_item.ch};
               req_tuser  <= cur_item.kind;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: switches between streaming, random stalls and heavy back-pressure
   rx_mode_type rx_mode      = RX_STREAM;
   int          rx_mode_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(10, 200);
         end
         rx_mode_left--;
         case (rx_mode)
            RX_STREAM: begin
               rsp_tready <= 1'b1;
            end
            RX_RANDOM: begin
               rsp_tready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
               rsp_tready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   // monitor: each segment transfer is checked against the oldest expectation
   always @(posedge clock) begin
      segment_type got;
      segment_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.start_col  = rsp_tdata[COL_W-1:0];
         got.end_col    = rsp_tdata[2*COL_W-1:COL_W];
         got.seg_height = rsp_tdata[2*COL_W+wwpw_pkg::HEIGHT_W-1:2*COL_W];
         got.line_end   = rsp_tlast;
         if (expected_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected segment start %0d end %0d height %0d last %0b",
                        $realtime, got.start_col, got.end_col, got.seg_height, got.line_end);
         end else begin
            want = expected_segments.pop_front();
            segs_checked++;
            if (!want.line_end)
               wraps_checked++;
            if (got.start_col != want.start_col || got.end_col != want.end_col ||
                got.seg_height != want.seg_height || got.line_end != want.line_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: segment mismatch: expected start %0d end %0d height %0d ",
                            "last %0b, got start %0d end %0d height %0d last %0b"},
                           $realtime, want.start_col, want.end_col, want.seg_height,
                           want.line_end, got.start_col, got.end_col, got.seg_height,
                           got.line_end);
            end
         end
      end
   end

   task automatic push_char(input logic [wwpw_pkg::CHAR_W-1:0] ch,
                            input logic [wwpw_pkg::ADV_W-1:0] adv,
                            input logic [wwpw_pkg::HEIGHT_W-1:0] ht);
      queue_item('{wwpw_pkg::KIND_CHAR, ch, adv, ht});
   endtask

   // end-of-line item with junk in the unused fields
   task automatic push_eol();
      queue_item('{wwpw_pkg::KIND_EOL, 8'($urandom_range(0, 255)),
                   12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095))});
      lines_closed++;
   endtask

   // random words separated by spaces and tabs, with occasional odd bytes and extremes
   task automatic push_line(input int n_chars, input int adv_hi, input bit close);
      int                            r;
      logic [wwpw_pkg::CHAR_W-1:0]   c;
      logic [wwpw_pkg::ADV_W-1:0]    a;
      logic [wwpw_pkg::HEIGHT_W-1:0] h;
      for (int i = 0; i < n_chars; i++) begin
         r = $urandom_range(0, 99);
         if (r < 15)      c = wwpw_pkg::CHAR_SPACE;
         else if (r < 20) c = wwpw_pkg::CHAR_TAB;
         else if (r < 27) c = 8'($urandom_range(0, 255));
         else             c = 8'($urandom_range(8'h61, 8'h7a));
         r = $urandom_range(0, 99);
         if (r < 4)       a = '0;
         else if (r < 7)  a = '1;
         else if (r < 10) a = 12'($urandom_range(0, 4095));
         else             a = 12'($urandom_range(1, adv_hi));
         r = $urandom_range(0, 99);
         if (r < 5)       h = '0;
         else if (r < 10) h = '1;
         else if (r < 20) h = 12'($urandom_range(0, 4095));
         else             h = 12'($urandom_range(8, 40));
         push_char(c, a, h);
      end
      if (close)
         push_eol();
   endtask

   // wait until the sender is drained and every segment is back, then let the pipe settle
   task automatic wait_idle();
      do @(negedge clock);
      while (text_items.size() != 0 || req_tvalid || expected_segments.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic reconfigure(input logic [wwpw_pkg::UWIDTH_W-1:0] w,
                              input logic [wwpw_pkg::HEIGHT_W-1:0] h);
      wait_idle();
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= wwpw_pkg::CSR_USABLE_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_addr  <= wwpw_pkg::CSR_EMPTY_HEIGHT;
      csr_wdata <= {{(wwpw_pkg::CSR_DATA_W - wwpw_pkg::HEIGHT_W){1'b0}}, h};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_usable_width = w;
      cfg_empty_height = h;
   endtask

   // stimulus
   initial begin
      int unsigned w;
      int          adv_hi;
      int          budget;
      int          n;
      @(negedge reset);

      // reset registers: wrapping off, empty height 16
      push_eol();                          // empty line
      push_char(8'h41, '1, '1);
      push_char(wwpw_pkg::CHAR_TAB, '0, '0);
      queue_item('{wwpw_pkg::KIND_EOL, 8'hFF, '1, '1});
      lines_closed++;

      // narrow line, zero empty height: leading space, soft break, hard cut
      reconfigure(16'd30, '0);
      push_char(wwpw_pkg::CHAR_SPACE, 12'd5, '0);
      push_char(8'h61, 12'd10, 12'd7);
      push_char(8'h62, 12'd10, '0);
      push_char(wwpw_pkg::CHAR_TAB, 12'd5, 12'd3);
      push_char(8'h63, 12'd10, 12'd9);
      push_char(8'h64, '1, 12'd2);
      push_char(8'hFF, '0, '0);
      push_char(8'h00, 12'd30, '1);
      push_eol();

      // one-pixel width: hard cuts between visible characters, whitespace-only line
      reconfigure(16'd1, '1);
      push_eol();
      push_char(8'h61, 12'd1, 12'd4);
      push_char(8'h62, '0, 12'd5);
      push_char(8'h63, 12'd1, 12'd6);
      push_char(wwpw_pkg::CHAR_SPACE, 12'd1, '0);
      push_eol();
      push_char(wwpw_pkg::CHAR_SPACE, 12'd1, 12'd1);
      push_char(wwpw_pkg::CHAR_TAB, 12'd1, 12'd2);
      push_eol();

      // random phases; some end mid-line so the width changes under an open line
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: w = 0;
            1: w = 1;
            2: w = 16'hFFFF;
            default: w = $urandom_range(2, p[0] ? 400 : 65534);
         endcase
         reconfigure(16'(w),
                     (p == 2) ? 12'd0 : (p == 3) ? 12'hFFF : 12'($urandom_range(0, 4095)));
         adv_hi = (w == 0) ? 60 : (w / 6 < 1) ? 1 : (w / 6 > 4095) ? 4095 : w / 6;
         budget = 90;
         while (budget > 0) begin
            n = $urandom_range(0, 9);
            n = (n == 0) ? 0 : (n == 1) ? $urandom_range(41, 120) : $urandom_range(1, 40);
            push_line(n, adv_hi, 1'b1);
            budget -= n + 1;
         end
         if ($urandom_range(0, 2) == 0)
            push_line($urandom_range(3, 15), adv_hi, 1'b0);
      end

      // long line: width sum saturates with wrapping off, then wrapping comes on mid-line
      reconfigure('0, 12'($urandom_range(0, 4095)));
      for (int i = 0; i < 300; i++)
         push_char((i % 5 == 4) ? wwpw_pkg::CHAR_SPACE : 8'h6d, '1,
                   12'($urandom_range(0, 4095)));
      reconfigure(16'hFFFF, 12'($urandom_range(1, 4095)));
      push_line(40, 20, 1'b1);

      // a last short stretch at a moderate width
      reconfigure(16'd200, 12'd16);
      push_line(60, 30, 1'b1);
      push_eol();

      wait_idle();
      repeat (10) @(negedge clock);

      $display("run covered %0d items over %0d lines, including a saturated long line",
               items_accepted, lines_closed);
      $display("checked %0d segments (%0d of them wraps), %0d mismatches",
               segs_checked, wraps_checked, mismatches);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // hang guard
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/wwpw_pkg.sv
rtl/word_wrap_by_pixel_width_unit.sv
tb/tb_word_wrap_by_pixel_width_unit.sv
